// ===== hw/rtl/hoi_pkg.sv =====
// shared types and constants of the hierarchical occupancy index
package hoi_pkg;

	localparam int MaxLevels = 3;
	localparam int MaxBranch = 16;
	localparam int IdxW      = 4;
	localparam int CountW    = 13;
	localparam int CountMax  = 4096;
	localparam int LeafDepth = MaxBranch * MaxBranch;
	localparam int LeafAw    = 8;
	localparam int AddrW     = 4;

	typedef enum logic [2:0] {
		FUNC_TEST   = 3'd0,
		FUNC_INSERT = 3'd1,
		FUNC_ERASE  = 3'd2,
		FUNC_NEXT   = 3'd3,
		FUNC_PREV   = 3'd4,
		FUNC_CLEAR  = 3'd5
	} func_t;

	localparam logic [1:0] REG_LEVELS  = 2'd0;
	localparam logic [1:0] REG_BRANCH0 = 2'd1;
	localparam logic [1:0] REG_BRANCH1 = 2'd2;
	localparam logic [1:0] REG_BRANCH2 = 2'd3;

	typedef struct packed {
		logic [2:0]      func;
		logic [IdxW-1:0] index_level0;
		logic [IdxW-1:0] index_level1;
		logic [IdxW-1:0] index_level2;
		logic            inclusive;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic              changed;
		logic [IdxW-1:0]   found_level0;
		logic [IdxW-1:0]   found_level1;
		logic [IdxW-1:0]   found_level2;
		logic [CountW-1:0] entry_count;
	} res_t;

	// geometry after saturation
	typedef struct packed {
		logic [1:0]      levels;
		logic [IdxW-1:0] max0;
		logic [IdxW-1:0] max1;
		logic [IdxW-1:0] max2;
	} geom_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD,
		ST_WAIT,
		ST_EVAL,
		ST_WRITE,
		ST_FIND,
		ST_DONE
	} state_t;

	function automatic logic [IdxW-1:0] sat_max(input logic [4:0] b);
		logic [4:0] c;
		c = b;
		if (c < 5'd2) c = 5'd2;
		if (c > 5'(MaxBranch)) c = 5'(MaxBranch);
		return IdxW'(c - 5'd1);
	endfunction

	// lowest set bit at or above pos, limited to max; found flag in msb
	function automatic logic [IdxW:0] scan_up(input logic [MaxBranch-1:0] m,
			input logic [IdxW-1:0] pos, input logic [IdxW-1:0] lim);
		logic [IdxW:0] r;
		r = '0;
		for (int i = MaxBranch - 1; i >= 0; i--) begin
			if (m[i] && IdxW'(i) >= pos && IdxW'(i) <= lim) r = {1'b1, IdxW'(i)};
		end
		return r;
	endfunction

	function automatic logic [IdxW:0] scan_down(input logic [MaxBranch-1:0] m,
			input logic [IdxW-1:0] pos);
		logic [IdxW:0] r;
		r = '0;
		for (int i = 0; i < MaxBranch; i++) begin
			if (m[i] && IdxW'(i) <= pos) r = {1'b1, IdxW'(i)};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/hoi_ram.sv =====
// generic single-port ram with registered read
module hoi_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

// ===== hw/rtl/hoi_cfg.sv =====
// apb register file holding geometry
module hoi_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output hoi_pkg::geom_t      geom
);

	logic [1:0] levels_q;
	logic [4:0] br0_q, br1_q, br2_q;
	logic [1:0] sel;

	assign sel = paddr[3:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= 2'd3;
			br0_q <= 5'd16;
			br1_q <= 5'd16;
			br2_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			case (sel)
				hoi_pkg::REG_LEVELS:  levels_q <= pwdata[1:0];
				hoi_pkg::REG_BRANCH0: br0_q <= pwdata[4:0];
				hoi_pkg::REG_BRANCH1: br1_q <= pwdata[4:0];
				hoi_pkg::REG_BRANCH2: br2_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			hoi_pkg::REG_LEVELS:  prdata = {30'd0, levels_q};
			hoi_pkg::REG_BRANCH0: prdata = {27'd0, br0_q};
			hoi_pkg::REG_BRANCH1: prdata = {27'd0, br1_q};
			default:              prdata = {27'd0, br2_q};
		endcase
	end

	always_comb begin
		geom.levels = (levels_q == 2'd0) ? 2'd1 : levels_q;
		geom.max0 = hoi_pkg::sat_max(br0_q);
		geom.max1 = hoi_pkg::sat_max(br1_q);
		geom.max2 = hoi_pkg::sat_max(br2_q);
	end

endmodule

// ===== hw/rtl/hoi_ctrl.sv =====
// sequencer: read-modify-write of the three bitmap levels and the find walk
module hoi_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hoi_pkg::geom_t                geom,
	input  logic                          start,
	input  hoi_pkg::cmd_t                 cmd,
	output logic                          busy,
	output logic                          done,
	output hoi_pkg::res_t                 res,
	output logic                          leaf_we,
	output logic [hoi_pkg::LeafAw-1:0]    leaf_addr,
	output logic [hoi_pkg::MaxBranch-1:0] leaf_wdata,
	input  logic [hoi_pkg::MaxBranch-1:0] leaf_rdata,
	output logic                          mid_we,
	output logic [hoi_pkg::AddrW-1:0]     mid_addr,
	output logic [hoi_pkg::MaxBranch-1:0] mid_wdata,
	input  logic [hoi_pkg::MaxBranch-1:0] mid_rdata
);

	localparam int IW = hoi_pkg::IdxW;
	localparam int BW = hoi_pkg::MaxBranch;

	hoi_pkg::state_t state_q, state_d;
	logic [BW-1:0] top_q;
	logic [hoi_pkg::CountW-1:0] count_q;
	logic [hoi_pkg::LeafAw-1:0] clr_q;
	logic boot_q;
	logic [2:0] func_q;
	logic incl_q, fwd_q;
	logic [1:0] n_q;
	logic [IW-1:0] k0_q, k1_q, k2_q;
	logic [BW-1:0] leafv_q, midv_q;
	logic hit_q, changed_q, keep_q;
	// find walk: level being scanned and whether its own key is skipped
	logic [1:0] lv_q;
	logic excl_q, walk_q;
	logic clearing, is_find;

	// start extreme of a level: zero going up, maximum going down
	function automatic logic [IW-1:0] ext(input logic f, input logic [IW-1:0] mx);
		return f ? '0 : mx;
	endfunction

	// saturated key inputs
	logic [IW-1:0] s0, s1, s2;
	always_comb begin
		s0 = (cmd.index_level0 > geom.max0) ? geom.max0 : cmd.index_level0;
		s1 = (geom.levels < 2'd2) ? '0 :
			(cmd.index_level1 > geom.max1) ? geom.max1 : cmd.index_level1;
		s2 = (geom.levels < 2'd3) ? '0 :
			(cmd.index_level2 > geom.max2) ? geom.max2 : cmd.index_level2;
	end

	assign clearing = state_q == hoi_pkg::ST_CLEAR;
	assign busy = state_q != hoi_pkg::ST_IDLE;
	assign leaf_addr = clearing ? clr_q : {k2_q, k1_q};
	assign mid_addr  = clearing ? clr_q[hoi_pkg::AddrW-1:0] : k2_q;
	assign is_find = func_q == 3'(hoi_pkg::FUNC_NEXT) || func_q == 3'(hoi_pkg::FUNC_PREV);

	// presence along path
	logic b_top, b_mid, b_leaf, pres;
	always_comb begin
		b_top  = top_q[k2_q];
		b_mid  = midv_q[k1_q];
		b_leaf = leafv_q[k0_q];
		case (n_q)
			2'd1:    pres = b_leaf;
			2'd2:    pres = b_mid && b_leaf;
			default: pres = b_top && b_mid && b_leaf;
		endcase
	end

	// find helpers for the current level; a bitmap only counts when its path is set
	logic [BW-1:0] map_l;
	logic [IW-1:0] key_l, max_l, pos_l;
	logic [IW:0] sc;
	logic live_l, empty_l, found_l, last_lv;
	always_comb begin
		case (lv_q)
			2'd0: begin
				map_l = leafv_q; key_l = k0_q; max_l = geom.max0;
				live_l = (n_q < 2'd2 || b_mid) && (n_q < 2'd3 || b_top);
			end
			2'd1: begin
				map_l = midv_q; key_l = k1_q; max_l = geom.max1;
				live_l = n_q < 2'd3 || b_top;
			end
			default: begin
				map_l = top_q; key_l = k2_q; max_l = geom.max2;
				live_l = 1'b1;
			end
		endcase
		empty_l = excl_q && (fwd_q ? key_l == max_l : key_l == '0);
		if (!excl_q) pos_l = key_l;
		else pos_l = fwd_q ? key_l + IW'(1) : key_l - IW'(1);
		sc = fwd_q ? hoi_pkg::scan_up(map_l, pos_l, max_l)
			: hoi_pkg::scan_down(map_l, pos_l);
		found_l = sc[IW] && live_l && !empty_l;
	end

	assign last_lv = lv_q == n_q - 2'd1;

	always_comb begin
		state_d = state_q;
		leaf_we = 1'b0;
		mid_we = 1'b0;
		leaf_wdata = '0;
		mid_wdata = '0;
		case (state_q)
			hoi_pkg::ST_IDLE: if (start) begin
				state_d = (cmd.func == 3'(hoi_pkg::FUNC_CLEAR)) ?
					hoi_pkg::ST_CLEAR : hoi_pkg::ST_RD;
			end
			hoi_pkg::ST_CLEAR: begin
				leaf_we = 1'b1;
				mid_we = clr_q < 8'(BW);
				// the sweep after reset returns no word
				if (clr_q == 8'(hoi_pkg::LeafDepth - 1))
					state_d = boot_q ? hoi_pkg::ST_IDLE : hoi_pkg::ST_DONE;
			end
			hoi_pkg::ST_RD:   state_d = hoi_pkg::ST_WAIT;
			hoi_pkg::ST_WAIT: state_d = walk_q ? hoi_pkg::ST_FIND : hoi_pkg::ST_EVAL;
			hoi_pkg::ST_EVAL: begin
				case (func_q)
					3'(hoi_pkg::FUNC_INSERT), 3'(hoi_pkg::FUNC_ERASE):
						state_d = hoi_pkg::ST_WRITE;
					3'(hoi_pkg::FUNC_NEXT), 3'(hoi_pkg::FUNC_PREV):
						state_d = hoi_pkg::ST_FIND;
					default: state_d = hoi_pkg::ST_DONE;
				endcase
			end
			hoi_pkg::ST_WRITE: begin
				if (func_q == 3'(hoi_pkg::FUNC_INSERT)) begin
					// fresh subtrees start empty
					leaf_we = 1'b1;
					leaf_wdata = ((n_q >= 2'd2 && !b_mid) || (n_q == 2'd3 && !b_top) ?
						'0 : leafv_q) | (BW'(1) << k0_q);
					mid_we = n_q >= 2'd2;
					mid_wdata = ((n_q == 2'd3 && !b_top) ? '0 : midv_q) | (BW'(1) << k1_q);
				end else if (pres) begin
					leaf_we = 1'b1;
					leaf_wdata = leafv_q & ~(BW'(1) << k0_q);
					mid_we = n_q >= 2'd2 && leaf_wdata == '0;
					mid_wdata = midv_q & ~(BW'(1) << k1_q);
				end
				state_d = hoi_pkg::ST_DONE;
			end
			hoi_pkg::ST_FIND: begin
				if (found_l) state_d = (lv_q == 2'd0) ? hoi_pkg::ST_DONE : hoi_pkg::ST_RD;
				else if (last_lv) state_d = hoi_pkg::ST_DONE;
			end
			hoi_pkg::ST_DONE: state_d = hoi_pkg::ST_IDLE;
			default: state_d = hoi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hoi_pkg::ST_CLEAR;
			top_q <= '0;
			count_q <= '0;
			clr_q <= '0;
			boot_q <= 1'b1;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= state_q == hoi_pkg::ST_DONE;
			if (state_q == hoi_pkg::ST_IDLE && start) begin
				clr_q <= '0;
				if (cmd.func == 3'(hoi_pkg::FUNC_CLEAR)) begin
					top_q <= '0;
					count_q <= '0;
				end
			end
			if (clearing) clr_q <= clr_q + 8'd1;
			if (clearing && clr_q == 8'(hoi_pkg::LeafDepth - 1)) boot_q <= 1'b0;
			if (state_q == hoi_pkg::ST_WRITE) begin
				if (func_q == 3'(hoi_pkg::FUNC_INSERT)) begin
					if (n_q == 2'd3) top_q <= top_q | (BW'(1) << k2_q);
					if (!b_leaf || (n_q >= 2'd2 && !b_mid) || (n_q == 2'd3 && !b_top))
						if (count_q < 13'(hoi_pkg::CountMax)) count_q <= count_q + 13'd1;
				end else if (pres) begin
					if (count_q != '0) count_q <= count_q - 13'd1;
					if (n_q == 2'd3 && leaf_wdata == '0 && mid_wdata == '0)
						top_q <= top_q & ~(BW'(1) << k2_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hoi_pkg::ST_IDLE: if (start) begin
				func_q <= cmd.func;
				incl_q <= cmd.inclusive;
				fwd_q <= cmd.func == 3'(hoi_pkg::FUNC_NEXT);
				n_q <= geom.levels;
				k0_q <= s0;
				k1_q <= s1;
				k2_q <= s2;
				hit_q <= 1'b0;
				changed_q <= 1'b0;
				keep_q <= cmd.func <= 3'(hoi_pkg::FUNC_PREV);
				lv_q <= '0;
				excl_q <= 1'b0;
				walk_q <= 1'b0;
			end
			hoi_pkg::ST_WAIT: begin
				leafv_q <= leaf_rdata;
				midv_q <= (n_q >= 2'd2) ? mid_rdata : '0;
			end
			hoi_pkg::ST_EVAL: begin
				if (func_q <= 3'(hoi_pkg::FUNC_ERASE)) hit_q <= pres;
				if (is_find) begin
					// strict search skips the start key at level 0
					walk_q <= 1'b1;
					lv_q <= '0;
					excl_q <= !incl_q;
				end
			end
			hoi_pkg::ST_WRITE: changed_q <= func_q == 3'(hoi_pkg::FUNC_INSERT) ?
				(!b_leaf || (n_q >= 2'd2 && !b_mid) || (n_q == 2'd3 && !b_top)) : pres;
			hoi_pkg::ST_FIND: begin
				if (found_l) begin
					excl_q <= 1'b0;
					case (lv_q)
						2'd0: begin k0_q <= sc[IW-1:0]; hit_q <= 1'b1; end
						2'd1: begin
							k1_q <= sc[IW-1:0];
							k0_q <= ext(fwd_q, geom.max0);
							lv_q <= 2'd0;
						end
						default: begin
							k2_q <= sc[IW-1:0];
							k1_q <= ext(fwd_q, geom.max1);
							lv_q <= 2'd1;
						end
					endcase
				end else if (!last_lv) begin
					// nothing left in this bitmap: climb and skip the parent key
					lv_q <= lv_q + 2'd1;
					excl_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// not-found tuple is all zeros (next) or maxima (prev)
	always_comb begin
		res.hit = hit_q;
		res.changed = changed_q;
		res.entry_count = count_q;
		if (!keep_q) begin
			res.found_level0 = '0;
			res.found_level1 = '0;
			res.found_level2 = '0;
		end else if (is_find && !hit_q) begin
			res.found_level0 = ext(fwd_q, geom.max0);
			res.found_level1 = n_q >= 2'd2 ? ext(fwd_q, geom.max1) : '0;
			res.found_level2 = n_q == 2'd3 ? ext(fwd_q, geom.max2) : '0;
		end else begin
			res.found_level0 = k0_q;
			res.found_level1 = k1_q;
			res.found_level2 = k2_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 13'(hoi_pkg::CountMax)) else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hoi_pkg::ST_IDLE && start) |=> busy) else $error("start lost");

endmodule

// ===== hw/rtl/hierarchical_occupancy_index.sv =====
// top level of the hierarchical occupancy index
//  channel  | signals                       | handshake
//  command  | start, busy, cmd              | taken when start && !busy
//  result   | done, res                     | one-cycle strobe, no back-pressure
//  config   | psel..pready                  | apb write, pready tied high
// a test reads both memories, waits for the registered data and evaluates; inserts and
// erases add a write back, and busy stays high until the done state has passed
// finds add a scan step for each bitmap scanned and a read and a wait for each child bitmap read
// clear all sweeps the 256-entry leaf memory
// reset starts the same sweep with busy high, so the set comes up empty
module hierarchical_occupancy_index (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  hoi_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output hoi_pkg::res_t res,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	hoi_pkg::geom_t geom;
	logic leaf_we, mid_we;
	logic [hoi_pkg::LeafAw-1:0] leaf_addr;
	logic [hoi_pkg::AddrW-1:0] mid_addr;
	logic [hoi_pkg::MaxBranch-1:0] leaf_wdata, leaf_rdata, mid_wdata, mid_rdata;

	hoi_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .geom);

	hoi_ram #(.Width(hoi_pkg::MaxBranch), .Depth(hoi_pkg::LeafDepth)) u_leaf (
		.clk, .we(leaf_we), .addr(leaf_addr), .wdata(leaf_wdata), .rdata(leaf_rdata));

	hoi_ram #(.Width(hoi_pkg::MaxBranch), .Depth(hoi_pkg::MaxBranch)) u_mid (
		.clk, .we(mid_we), .addr(mid_addr), .wdata(mid_wdata), .rdata(mid_rdata));

	hoi_ctrl u_ctrl (.clk, .arst_n, .geom, .start, .cmd, .busy, .done, .res,
		.leaf_we, .leaf_addr, .leaf_wdata, .leaf_rdata,
		.mid_we, .mid_addr, .mid_wdata, .mid_rdata);

endmodule
